>>> rtl/mlfs_pkg.sv
// ----------------------------------------------------------------------------
// mlfs_pkg
// shared types and codes for the multilevel feedback scheduler
// ----------------------------------------------------------------------------
package mlfs_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int MAX_LEVEL_DEF = 15;

  localparam int TASK_W  = 8;
  localparam int USED_W  = 16;
  localparam int STAMP_W = 32;

  // action codes
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_RUN = 2'd1;
  localparam logic [1:0] ACT_POP = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // slot update commands
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;
  localparam logic [1:0] CMD_POP  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [TASK_W-1:0]  task_id;
    logic               head_finishes;
    logic [STAMP_W-1:0] now;
  } request_t;

  typedef struct packed {
    logic [TASK_W-1:0] chosen_id;
    logic [1:0]        status;
    logic [TASK_W-1:0] head_id;
    logic              table_empty;
  } result_t;

  // update broadcast to the slot cells
  typedef struct packed {
    logic [1:0]         op;
    logic [TASK_W-1:0]  task_id;
    logic               finishes;
    logic [STAMP_W-1:0] now;
  } cell_cmd_t;

  // fixed-width part of the scan token passed along the cells
  typedef struct packed {
    logic               head_found;
    logic               free_found;
    logic [TASK_W-1:0]  head_task;
    logic [STAMP_W-1:0] head_stamp;
  } scan_fix_t;

endpackage

>>> rtl/mlfs_cell.sv
// ----------------------------------------------------------------------------
// mlfs_cell
// one task slot plus one stage of the head / free-slot scan chain
// ----------------------------------------------------------------------------
module mlfs_cell
  import mlfs_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int INDEX     = 0,
  localparam int IDX_W    = $clog2(SLOTS),
  localparam int LVL_W    = $clog2(MAX_LEVEL + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] target,
  input  scan_fix_t        scan_in,
  input  logic [IDX_W-1:0] scan_in_head_idx,
  input  logic [LVL_W-1:0] scan_in_head_level,
  input  logic [IDX_W-1:0] scan_in_free_idx,
  output scan_fix_t        scan_out,
  output logic [IDX_W-1:0] scan_out_head_idx,
  output logic [LVL_W-1:0] scan_out_head_level,
  output logic [IDX_W-1:0] scan_out_free_idx
);

  logic               valid;
  logic [TASK_W-1:0]  task_id;
  logic [LVL_W-1:0]   level;
  logic [USED_W-1:0]  used;
  logic [STAMP_W-1:0] stamp;

  logic               sel;
  logic [USED_W-1:0]  used_inc;
  logic [7:0]         level_ext;
  logic               quantum_done;
  logic               better;

  assign sel       = (cmd.op != CMD_NONE) && (target == IDX_W'(INDEX));
  assign used_inc  = (used != {USED_W{1'b1}}) ? used + USED_W'(1) : used;
  assign level_ext = 8'(level);
  // quantum is 2^level; beyond 2^16 the saturated counter never gets there
  assign quantum_done = (level_ext <= 8'd16) &&
                        ({1'b0, used_inc} >= ((USED_W+1)'(1) << level));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        CMD_ADD: begin
          valid   <= 1'b1;
          task_id <= cmd.task_id;
          level   <= '0;
          used    <= '0;
          stamp   <= cmd.now;
        end
        CMD_POP: begin
          valid <= 1'b0;
        end
        CMD_RUN: begin
          if (!cmd.finishes) begin
            if (quantum_done) begin
              if (level != LVL_W'(MAX_LEVEL)) begin
                level <= level + LVL_W'(1);
              end
              used  <= '0;
              stamp <= cmd.now;
            end else begin
              used <= used_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // strict compare keeps the lower slot on equal keys
  assign better = valid && (!scan_in.head_found ||
                            (level < scan_in_head_level) ||
                            ((level == scan_in_head_level) &&
                             (stamp < scan_in.head_stamp)));

  always_ff @(posedge clk) begin
    if (better) begin
      scan_out.head_found <= 1'b1;
      scan_out.head_task  <= task_id;
      scan_out.head_stamp <= stamp;
      scan_out_head_idx   <= IDX_W'(INDEX);
      scan_out_head_level <= level;
    end else begin
      scan_out.head_found <= scan_in.head_found;
      scan_out.head_task  <= scan_in.head_task;
      scan_out.head_stamp <= scan_in.head_stamp;
      scan_out_head_idx   <= scan_in_head_idx;
      scan_out_head_level <= scan_in_head_level;
    end
    if (!scan_in.free_found && !valid) begin
      scan_out.free_found <= 1'b1;
      scan_out_free_idx   <= IDX_W'(INDEX);
    end else begin
      scan_out.free_found <= scan_in.free_found;
      scan_out_free_idx   <= scan_in_free_idx;
    end
  end

endmodule

>>> rtl/multilevel_feedback_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// multilevel feedback scheduler over a row of task slot cells
// ----------------------------------------------------------------------------
//   channel   direction  payload     handshake
//   request   in         request_t   request_valid / request_stall
//   result    out        result_t    result_valid / result_stall
//
// an item is handled in order: transfer and update the target slot, let the
// scan token walk the cell chain, one register per slot, then post the result.
// the scan chain has one cell per slot.
// rst is synchronous; after it the table is empty and the first free slot is 0.
// a stalled result waits in its register; the next request transfers meanwhile.
module multilevel_feedback_scheduler_core
  import mlfs_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     request_valid,
  output logic     request_stall,
  input  request_t request,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int LVL_W = $clog2(MAX_LEVEL + 1);
  localparam int CNT_W = $clog2(SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;

  // head and free slot as of the last completed scan
  logic              head_found;
  logic [IDX_W-1:0]  head_idx;
  logic [TASK_W-1:0] head_task;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // per-item result fields known at transfer time
  logic [TASK_W-1:0] chosen;
  logic [1:0]        status;

  logic              take;
  logic              post;
  cell_cmd_t         cmd;
  logic [IDX_W-1:0]  target;
  logic [TASK_W-1:0] chosen_next;
  logic [1:0]        status_next;

  // scan chain wiring, entry 0 is the empty token
  scan_fix_t        chain       [SLOTS+1];
  logic [IDX_W-1:0] chain_hidx  [SLOTS+1];
  logic [LVL_W-1:0] chain_level [SLOTS+1];
  logic [IDX_W-1:0] chain_fidx  [SLOTS+1];

  assign chain[0]       = '0;
  assign chain_hidx[0]  = '0;
  assign chain_level[0] = '0;
  assign chain_fidx[0]  = '0;

  assign request_stall = (state != ST_IDLE);
  assign take          = request_valid && !request_stall;
  // result register frees up when empty or when its transfer happens now
  assign post          = (state == ST_DONE) && (!result_valid || !result_stall);

  // decode the request against the stored head and free slot
  always_comb begin
    cmd.op       = CMD_NONE;
    cmd.task_id  = request.task_id;
    cmd.finishes = request.head_finishes;
    cmd.now      = request.now;
    target       = head_idx;
    chosen_next  = '0;
    status_next  = STAT_OK;
    case (request.action)
      ACT_ADD: begin
        target = free_idx;
        if (free_found) begin
          cmd.op = CMD_ADD;
        end else begin
          status_next = STAT_FULL;
        end
      end
      ACT_RUN: begin
        if (head_found) begin
          cmd.op      = CMD_RUN;
          chosen_next = head_task;
        end else begin
          status_next = STAT_EMPTY;
        end
      end
      ACT_POP: begin
        if (head_found) begin
          cmd.op      = CMD_POP;
          chosen_next = head_task;
        end else begin
          status_next = STAT_EMPTY;
        end
      end
      default: begin
      end
    endcase
    // only an accepted request touches the table
    if (!take) begin
      cmd.op = CMD_NONE;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mlfs_cell #(
      .SLOTS     (SLOTS),
      .MAX_LEVEL (MAX_LEVEL),
      .INDEX     (i)
    ) u_cell (
      .clk                 (clk),
      .rst                 (rst),
      .cmd                 (cmd),
      .target              (target),
      .scan_in             (chain[i]),
      .scan_in_head_idx    (chain_hidx[i]),
      .scan_in_head_level  (chain_level[i]),
      .scan_in_free_idx    (chain_fidx[i]),
      .scan_out            (chain[i+1]),
      .scan_out_head_idx   (chain_hidx[i+1]),
      .scan_out_head_level (chain_level[i+1]),
      .scan_out_free_idx   (chain_fidx[i+1])
    );
  end

  // sequencer: transfer, walk the chain, post
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          // last cell register loads on this edge
          if (cnt == CNT_W'(SLOTS - 1)) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (post) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      chosen <= chosen_next;
      status <= status_next;
    end
  end

  // scan outcome becomes the stored head / free slot for the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      head_found <= 1'b0;
      head_idx   <= '0;
      head_task  <= '0;
      free_found <= 1'b1;
      free_idx   <= '0;
    end else if (post) begin
      head_found <= chain[SLOTS].head_found;
      head_idx   <= chain_hidx[SLOTS];
      head_task  <= chain[SLOTS].head_task;
      free_found <= chain[SLOTS].free_found;
      free_idx   <= chain_fidx[SLOTS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (post) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      result.chosen_id   <= chosen;
      result.status      <= status;
      result.head_id     <= chain[SLOTS].head_found ? chain[SLOTS].head_task : '0;
      result.table_empty <= !chain[SLOTS].head_found;
    end
  end

endmodule

>>> bench/multilevel_feedback_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core_tb
// self-checking bench for the multilevel feedback scheduler core; a local
// copy of the slot table predicts every result, requests and result stalls
// are randomized, and a long tick run walks one task down several levels
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core_tb;
  import mlfs_pkg::*;

  // action code the block must treat as a no-op
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // cycles with no transfer on either side before the run is declared hung;
  // the limit must cover one item plus the random idle gaps on each side
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_CYCLES = SLOTS_DEF + 2;
  localparam int RANDOM_ITEMS = 1600;
  // levels walked by the tick ladder, and the ticks that takes
  localparam int LADDER_LEVELS = 8;
  localparam int LADDER_TICKS = (1 << LADDER_LEVELS) - 1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  request_t request = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  result_t  result;

  multilevel_feedback_scheduler_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // local slot table, updated once per request transfer
  // --------------------------------------------------------------------------
  bit          tab_live    [SLOTS_DEF];
  logic [7:0]  tab_task    [SLOTS_DEF];
  int unsigned tab_level   [SLOTS_DEF];
  int unsigned tab_spent   [SLOTS_DEF];
  logic [31:0] tab_entered [SLOTS_DEF];

  result_t     due_results[$];   // predicted results not yet seen
  int          error_count = 0;
  int          quiet_cycles = 0;
  int unsigned sched_clock = 0;  // slowly rising time base for stamps

  bit tx_idle = 1'b0;            // sender inserts random gaps
  bit rx_idle = 1'b0;            // receiver inserts random stalls
  int rx_hold = 0;               // stall cycles left on the offered result

  // head: lowest level, then earliest stamp, then lowest slot
  function automatic int head_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (tab_live[i] && (best < 0 || tab_level[i] < tab_level[best] ||
          (tab_level[i] == tab_level[best] && tab_entered[i] < tab_entered[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < SLOTS_DEF; i++)
      if (!tab_live[i]) return i;
    return -1;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS_DEF; i++) n += tab_live[i];
    return n;
  endfunction

  // apply one request to the local table and return the result it must give
  function automatic result_t advance_schedule(input request_t rq);
    result_t rs;
    int      h;
    int      f;
    rs = '0;
    rs.status = STAT_OK;
    case (rq.action)
      ACT_ADD: begin
        f = free_slot();
        if (f < 0) begin
          rs.status = STAT_FULL;
        end else begin
          tab_live[f]    = 1'b1;
          tab_task[f]    = rq.task_id;
          tab_level[f]   = 0;
          tab_spent[f]   = 0;
          tab_entered[f] = rq.now;
        end
      end
      ACT_RUN, ACT_POP: begin
        h = head_slot();
        if (h < 0) begin
          rs.status = STAT_EMPTY;
        end else begin
          rs.chosen_id = tab_task[h];
          if (rq.action == ACT_POP) begin
            tab_live[h] = 1'b0;
          end else if (!rq.head_finishes) begin
            // used quantum saturates at the width of its counter
            if (tab_spent[h] < 32'hFFFF) tab_spent[h]++;
            if (tab_spent[h] >= (32'd1 << tab_level[h])) begin
              // quantum used up: demote (stuck at the last level) and restamp
              if (tab_level[h] < MAX_LEVEL_DEF) tab_level[h]++;
              tab_spent[h]   = 0;
              tab_entered[h] = rq.now;
            end
          end
        end
      end
      default: ;
    endcase
    h = head_slot();
    if (h < 0) begin
      rs.head_id     = '0;
      rs.table_empty = 1'b1;
    end else begin
      rs.head_id     = tab_task[h];
      rs.table_empty = 1'b0;
    end
    return rs;
  endfunction

  // mostly a rising clock, sometimes the extremes or anything at all
  function automatic logic [31:0] next_stamp();
    int pick;
    sched_clock += $urandom_range(0, 3);
    pick = $urandom_range(0, 19);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    if (pick < 4) return $urandom;
    return sched_clock;
  endfunction

  // --------------------------------------------------------------------------
  // request side: entered and left just after a falling edge; valid stays
  // high between back-to-back items so it is never dropped and raised in
  // the same step
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] action, input logic [7:0] task_id,
                              input logic finishes, input logic [31:0] stamp);
    request_t rq;
    int       gap;
    rq.action        = action;
    rq.task_id       = task_id;
    rq.head_finishes = finishes;
    rq.now           = stamp;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request       <= rq;
    request_valid <= 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    due_results.insert(due_results.size(), advance_schedule(rq));
    @(negedge clk);
  endtask

  task automatic send_add();
    send_request(ACT_ADD, $urandom_range(0, 255), $urandom_range(0, 1), next_stamp());
  endtask

  // hold off new requests until every predicted result has come back
  task automatic wait_drained();
    request_valid <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  // stall a drawn number of cycles on each offered result, plus stray
  // stall pulses while nothing is offered
  always @(negedge clk) begin
    if (result_valid && rx_hold > 0) begin
      result_stall <= 1'b1;
      rx_hold--;
    end else if (!result_valid && rx_idle) begin
      result_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: chosen=%0h status=%0d head=%0h empty=%0b",
                   result.chosen_id, result.status, result.head_id, result.table_empty);
      end else begin
        want = due_results.pop_front();
        if (result.chosen_id !== want.chosen_id || result.status !== want.status ||
            result.head_id !== want.head_id || result.table_empty !== want.table_empty) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch at %0t: expected chosen=%0h status=%0d head=%0h empty=%0b,",
                      " got chosen=%0h status=%0d head=%0h empty=%0b"},
                     $time, want.chosen_id, want.status, want.head_id, want.table_empty,
                     result.chosen_id, result.status, result.head_id, result.table_empty);
        end
      end
      rx_hold = rx_idle ? $urandom_range(0, 13) : 0;
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // run and pop on an empty table, unused action code
  task automatic test_empty_table();
    send_request(ACT_POP, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_request(ACT_RUN, 8'h00, 1'b0, 32'h0000_0000);
    send_request(ACT_RUN, 8'h5A, 1'b1, 32'h1234_5678);
    send_request(ACT_UNUSED, 8'hA5, 1'b1, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // selection order, duplicate ids, finish flag, first demotion, pops
  task automatic test_head_order();
    send_request(ACT_ADD, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_request(ACT_ADD, 8'h00, 1'b0, 32'h0000_0000);
    // same id and same stamp: lower slot wins the tie
    send_request(ACT_ADD, 8'h00, 1'b0, 32'h0000_0000);
    send_request(ACT_UNUSED, 8'hA5, 1'b1, 32'h5A5A_5A5A);
    // finishing tick leaves the head untouched
    send_request(ACT_RUN, 8'h11, 1'b1, 32'h0000_0003);
    // level 0 quantum is one tick, so the head drops a level
    send_request(ACT_RUN, 8'h22, 1'b0, 32'h0000_0005);
    send_request(ACT_POP, 8'h33, 1'b0, 32'h0000_0006);
    send_request(ACT_RUN, 8'h44, 1'b0, 32'h0000_0007);
    send_request(ACT_POP, 8'h55, 1'b1, 32'h0000_0008);
    send_request(ACT_POP, 8'h66, 1'b0, 32'h0000_0009);
    wait_drained();
  endtask

  // one task ticked down through several levels with growing quanta;
  // a later add must then outrank it
  task automatic test_level_ladder();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_request(ACT_ADD, 8'h3C, 1'b0, sched_clock);
    repeat (LADDER_TICKS) begin
      sched_clock++;
      send_request(ACT_RUN, 8'h00, 1'b0, sched_clock);
    end
    sched_clock++;
    send_request(ACT_ADD, 8'hC3, 1'b0, sched_clock);
    sched_clock++;
    send_request(ACT_RUN, 8'h00, 1'b0, sched_clock);
    send_request(ACT_POP, 8'h00, 1'b0, sched_clock);
    send_request(ACT_POP, 8'h00, 1'b0, sched_clock);
    wait_drained();
  endtask

  // bursts of well-formed traffic with random content, plus noise
  task automatic test_random_traffic(input int target);
    int sent;
    int kind;
    int n;
    logic [1:0] act;
    sent = 0;
    while (sent < target) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        // fill to the top, then one add that must be refused
        while (live_count() < SLOTS_DEF) begin
          send_add();
          sent++;
        end
        send_add();
        sent++;
      end else if (kind < 6) begin
        // tick run, a quarter of the ticks finish the head
        n = $urandom_range(1, 40);
        repeat (n) begin
          send_request(ACT_RUN, $urandom_range(0, 255), ($urandom_range(0, 3) == 0),
                       next_stamp());
          sent++;
        end
      end else if (kind < 8) begin
        // partial drain, or live count plus one steps; some steps are runs, not pops
        n = ($urandom_range(0, 1) == 0) ? live_count() + 1 : $urandom_range(1, 8);
        repeat (n) begin
          send_request(($urandom_range(0, 3) == 0) ? ACT_RUN : ACT_POP,
                       $urandom_range(0, 255), $urandom_range(0, 1), next_stamp());
          sent++;
        end
      end else begin
        // noise over every field, unused code included
        n = $urandom_range(1, 12);
        repeat (n) begin
          act = $urandom_range(0, 3);
          send_request(act, $urandom_range(0, 255), $urandom_range(0, 1), $urandom);
          if (act != ACT_UNUSED) sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    test_head_order();
    test_level_ladder();
    test_random_traffic(RANDOM_ITEMS);

    // allow for anything still in flight, then judge
    repeat (4 * ITEM_CYCLES) @(negedge clk);
    if (due_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mlfs_pkg.sv
rtl/mlfs_cell.sv
rtl/multilevel_feedback_scheduler_core.sv
bench/multilevel_feedback_scheduler_core_tb.sv
